FILE: design/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants and types for the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned ArenaWords  = 65536;
  localparam int unsigned PageWords   = 512;
  localparam int unsigned RecentDepth = 5;

  localparam int unsigned AddrW  = $clog2(ArenaWords);   // header index width
  localparam int unsigned SizeW  = AddrW + 1;            // block size in words
  localparam int unsigned PageW  = $clog2(PageWords);
  localparam int unsigned RecW   = (RecentDepth > 1) ? $clog2(RecentDepth) : 1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StZero     = 3'd1;
  localparam logic [2:0] StOom      = 3'd2;
  localparam logic [2:0] StNull     = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

  // header word: free flag plus total size in words
  typedef struct packed {
    logic             free;
    logic [SizeW-1:0] words;
  } hdr_t;

  typedef enum logic [3:0] {
    CmdNone,
    CmdStart,      // latch request, load cursors
    CmdRecRead,    // read header of recent entry rec_idx
    CmdScanRead,   // read header at cursor
    CmdScanStep,   // cursor += size, or past break on zero size
    CmdGrow,       // write new grown block at break
    CmdSplit,      // split picked block
    CmdGrant,      // mark picked block in use, form result
    CmdFreeMark,   // mark cursor block free, push recent
    CmdFail        // form failure result
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [RecW-1:0] rec_idx;
    logic [2:0] fail_status;
    logic       pick_recent;   // on grant from recent list, drop entry
  } ctl_t;

  typedef struct packed {
    logic is_free_op;
    logic zero_size;
    logic null_addr;
    logic rec_hit;       // header read for recent entry fits
    logic rec_valid;     // recent entry rec_idx valid and below break
    logic cur_end;       // cursor at/past break, also after a zero size header
    logic cur_fit;       // header at cursor is free and fits
    logic cur_match;     // header at cursor matches free address, in use
    logic grow_oom;
    logic need_split;
  } sts_t;

endpackage

FILE: design/ffba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_datapath
// header memory, break/hint registers, recent list and result forming
// ----------------------------------------------------------------------------
module ffba_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      kind_i,
  input  logic [19:0]               size_bytes_i,
  input  logic [19:0]               address_i,
  input  ffba_pkg::ctl_t            ctl_i,
  output ffba_pkg::sts_t            sts_o,
  output logic [2:0]                status_o,
  output logic [19:0]               data_address_o,
  output logic [19:0]               granted_bytes_o
);

  localparam int unsigned AW = ffba_pkg::AddrW;
  localparam int unsigned SW = ffba_pkg::SizeW;
  localparam int unsigned RD = ffba_pkg::RecentDepth;

  ffba_pkg::hdr_t mem_q [ffba_pkg::ArenaWords];
  ffba_pkg::hdr_t rdata_q;

  logic            kind_q;
  logic [17:0]     a_q;          // request in words
  logic [19:0]     addr_q;
  logic [SW:0]     brk_q;        // break, may equal arena size
  logic [AW-1:0]   hint_q;
  logic [AW:0]     cur_q;
  logic [AW-1:0]   pick_q;
  logic [AW-1:0]   rec_q   [RD];
  logic            rec_v_q [RD];
  logic [2:0]      status_q;
  logic [19:0]     daddr_q, gbytes_q;

  // write port
  logic            we;
  logic [AW-1:0]   waddr;
  ffba_pkg::hdr_t  wdata;
  // picked block was split in the previous cycle, left half is a+1 words
  logic            split_q;

  logic [AW-1:0]   raddr;
  logic [18:0]     total;        // grown words
  logic [18:0]     a_p1;
  logic [SW:0]     grow_end;

  assign a_p1     = {1'b0, a_q} + 19'd1;
  assign total    = {(a_p1 >> ffba_pkg::PageW) + 19'd1} << ffba_pkg::PageW;
  assign grow_end = brk_q + total[SW:0];

  // reads default to the picked block so split and grant see its header
  always_comb begin
    raddr = pick_q;
    if (ctl_i.cmd == ffba_pkg::CmdRecRead) raddr = rec_q[ctl_i.rec_idx];
    else if (ctl_i.cmd == ffba_pkg::CmdScanRead) raddr = cur_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
    if (we) mem_q[waddr] <= wdata;
  end

  // status from registered header
  logic [SW-1:0] t;
  assign t = rdata_q.words;
  always_comb begin
    sts_o.is_free_op = kind_q;
    sts_o.zero_size  = (a_q == '0);
    sts_o.null_addr  = (addr_q == '0);
    sts_o.rec_valid  = rec_v_q[ctl_i.rec_idx] && ({2'b0, rec_q[ctl_i.rec_idx]} < brk_q);
    sts_o.rec_hit    = rdata_q.free && (t != '0) && (({1'b0, t} - 18'd1) >= a_q);
    sts_o.cur_end    = ({1'b0, cur_q} >= brk_q);
    sts_o.cur_fit    = sts_o.rec_hit;
    sts_o.cur_match  = !rdata_q.free && ({cur_q + 17'd1, 3'b000} == addr_q);
    sts_o.grow_oom   = (grow_end > (SW+1)'(ffba_pkg::ArenaWords));
    sts_o.need_split = ({2'b0, t} > {1'b0, a_q} + 19'd3);
  end

  logic zero_hdr;
  assign zero_hdr = (t == '0);

  always_comb begin
    we = 1'b0; waddr = pick_q; wdata = rdata_q;
    case (ctl_i.cmd)
      ffba_pkg::CmdGrow: begin
        we = 1'b1; waddr = brk_q[AW-1:0];
        wdata.free = 1'b1; wdata.words = total[SW-1:0];
      end
      ffba_pkg::CmdSplit: begin
        // right half first, left header is rewritten on grant
        we = 1'b1; waddr = pick_q + a_p1[AW-1:0];
        wdata.free = 1'b1; wdata.words = SW'({1'b0, t} - a_p1);
      end
      ffba_pkg::CmdGrant: begin
        we = 1'b1; waddr = pick_q;
        wdata.free = 1'b0; wdata.words = split_q ? a_p1[SW-1:0] : rdata_q.words;
      end
      ffba_pkg::CmdFreeMark: begin
        we = 1'b1; waddr = cur_q[AW-1:0];
        wdata.free = 1'b1; wdata.words = rdata_q.words;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q   <= '0;
      hint_q  <= '0;
      split_q <= 1'b0;
      for (int i = 0; i < RD; i++) begin
        rec_q[i]   <= '0;
        rec_v_q[i] <= 1'b0;
      end
    end else begin
      split_q <= 1'b0;
      case (ctl_i.cmd)
        ffba_pkg::CmdGrow: begin
          hint_q <= brk_q[AW-1:0];
          brk_q  <= grow_end;
        end
        ffba_pkg::CmdSplit: begin
          split_q <= 1'b1;
          hint_q  <= pick_q + a_p1[AW-1:0];
        end
        ffba_pkg::CmdGrant: begin
          if (ctl_i.pick_recent) rec_v_q[ctl_i.rec_idx] <= 1'b0;
        end
        ffba_pkg::CmdFreeMark: begin
          if (cur_q[AW-1:0] < hint_q) hint_q <= cur_q[AW-1:0];
          for (int i = RD-1; i > 0; i--) begin
            rec_q[i]   <= rec_q[i-1];
            rec_v_q[i] <= rec_v_q[i-1];
          end
          rec_q[0]   <= cur_q[AW-1:0];
          rec_v_q[0] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      ffba_pkg::CmdStart: begin
        kind_q <= kind_i;
        a_q    <= 18'((21'(size_bytes_i) + 21'd7) >> 3);
        addr_q <= address_i;
        cur_q  <= kind_i ? '0 : {1'b0, hint_q};
      end
      ffba_pkg::CmdRecRead: pick_q <= rec_q[ctl_i.rec_idx];
      ffba_pkg::CmdScanRead: pick_q <= cur_q[AW-1:0];
      ffba_pkg::CmdScanStep: begin
        if (zero_hdr) cur_q <= {1'b1, {AW{1'b0}}} | brk_q[AW:0];
        else          cur_q <= cur_q + (AW+1)'(t);
      end
      ffba_pkg::CmdGrow: pick_q <= brk_q[AW-1:0];
      ffba_pkg::CmdGrant: begin
        status_q <= ffba_pkg::StOk;
        daddr_q  <= 20'({pick_q, 3'b000} + 20'd8);
        gbytes_q <= split_q ? 20'({a_q, 3'b000}) : 20'({t - 1'b1, 3'b000});
      end
      ffba_pkg::CmdFreeMark: begin
        status_q <= ffba_pkg::StOk; daddr_q <= '0; gbytes_q <= '0;
      end
      ffba_pkg::CmdFail: begin
        status_q <= ctl_i.fail_status; daddr_q <= '0; gbytes_q <= '0;
      end
      default: ;
    endcase
  end

  assign status_o        = status_q;
  assign data_address_o  = daddr_q;
  assign granted_bytes_o = gbytes_q;

endmodule

FILE: design/ffba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// sequencer for allocate and free walks
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  ffba_pkg::sts_t   sts_i,
  output ffba_pkg::ctl_t   ctl_o
);

  typedef enum logic [3:0] {
    SIdle, SDecode, SRecAddr, SRecChk, SScanAddr, SScanChk, SGrow, SGrowRd,
    SSplit, SSplitWr, SGrant, SOut
  } state_e;

  state_e                    state_q;
  logic [ffba_pkg::RecW-1:0] idx_q;
  logic                      from_rec_q;

  assign in_stall_o  = (state_q != SIdle) && !(state_q == SOut && !out_stall_i);
  assign out_valid_o = (state_q == SOut);

  logic take;
  assign take = in_valid_i && !in_stall_o;

  always_comb begin
    ctl_o.cmd         = ffba_pkg::CmdNone;
    ctl_o.rec_idx     = idx_q;
    ctl_o.fail_status = ffba_pkg::StOk;
    ctl_o.pick_recent = from_rec_q;
    case (state_q)
      SIdle, SOut: if (take) ctl_o.cmd = ffba_pkg::CmdStart;
      SDecode: begin
        if (sts_i.is_free_op && sts_i.null_addr) begin
          ctl_o.cmd = ffba_pkg::CmdFail; ctl_o.fail_status = ffba_pkg::StNull;
        end else if (!sts_i.is_free_op && sts_i.zero_size) begin
          ctl_o.cmd = ffba_pkg::CmdFail; ctl_o.fail_status = ffba_pkg::StZero;
        end
      end
      SRecAddr: if (sts_i.rec_valid) ctl_o.cmd = ffba_pkg::CmdRecRead;
      SScanAddr: begin
        if (sts_i.cur_end) begin
          if (sts_i.is_free_op) begin
            ctl_o.cmd = ffba_pkg::CmdFail; ctl_o.fail_status = ffba_pkg::StNotFound;
          end
        end else ctl_o.cmd = ffba_pkg::CmdScanRead;
      end
      SScanChk: begin
        if (sts_i.is_free_op) begin
          ctl_o.cmd = sts_i.cur_match ? ffba_pkg::CmdFreeMark : ffba_pkg::CmdScanStep;
        end else if (!sts_i.cur_fit) ctl_o.cmd = ffba_pkg::CmdScanStep;
      end
      SGrow: begin
        if (sts_i.grow_oom) begin
          ctl_o.cmd = ffba_pkg::CmdFail; ctl_o.fail_status = ffba_pkg::StOom;
        end else ctl_o.cmd = ffba_pkg::CmdGrow;
      end
      SSplit:   ctl_o.cmd = sts_i.need_split ? ffba_pkg::CmdSplit : ffba_pkg::CmdNone;
      SGrant:   ctl_o.cmd = ffba_pkg::CmdGrant;
      default: ;
    endcase
  end

  logic last_idx;
  assign last_idx = (idx_q == ffba_pkg::RecW'(ffba_pkg::RecentDepth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      idx_q      <= '0;
      from_rec_q <= 1'b0;
    end else begin
      case (state_q)
        SIdle: if (take) state_q <= SDecode;
        SOut: begin
          if (take) state_q <= SDecode;
          else if (!out_stall_i) state_q <= SIdle;
        end
        SDecode: begin
          idx_q <= '0;
          from_rec_q <= 1'b0;
          if (ctl_o.cmd == ffba_pkg::CmdFail) state_q <= SOut;
          else if (sts_i.is_free_op) state_q <= SScanAddr;
          else state_q <= SRecAddr;
        end
        SRecAddr: begin
          if (sts_i.rec_valid) state_q <= SRecChk;
          else if (last_idx) state_q <= SScanAddr;
          else idx_q <= idx_q + 1'b1;
        end
        SRecChk: begin
          if (sts_i.rec_hit) begin
            from_rec_q <= 1'b1; state_q <= SSplit;
          end else if (last_idx) state_q <= SScanAddr;
          else begin
            idx_q <= idx_q + 1'b1; state_q <= SRecAddr;
          end
        end
        SScanAddr: begin
          if (!sts_i.cur_end) state_q <= SScanChk;
          else if (sts_i.is_free_op) state_q <= SOut;
          else state_q <= SGrow;
        end
        SScanChk: begin
          if (sts_i.is_free_op) state_q <= sts_i.cur_match ? SOut : SScanAddr;
          else state_q <= sts_i.cur_fit ? SSplit : SScanAddr;
        end
        SGrow:    state_q <= sts_i.grow_oom ? SOut : SGrowRd;
        SGrowRd:  state_q <= SSplitWr;   // header read back of grown block
        SSplitWr: state_q <= SSplit;
        SSplit:   state_q <= SGrant;
        SGrant:   state_q <= SOut;
        default:  state_q <= SIdle;
      endcase
    end
  end

  // the datapath reads the picked header whenever no walk read is issued;
  // SGrowRd reads back the grown header and SSplitWr holds it for SSplit
  ffba_ctrl_unused_guard : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_no_take_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScanChk) |-> in_stall_o) else $error("accept while busy");
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= ffba_pkg::RecW'(ffba_pkg::RecentDepth - 1)) else $error("recent index");

endmodule

FILE: design/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap allocator over a word-addressed header arena
// ----------------------------------------------------------------------------
// order: zero size and null free fail at decode; allocate decodes, checks
// the recent entries, walks headers from the hint, grows at the break,
// then splits if needed and grants; free decodes and walks headers from
// the start until a match or the break
// throughput: one request at a time; the next is taken as the result leaves
// reset: break, hint and recent list clear; header memory is not cleared
module first_fit_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [19:0] size_bytes_i,
  input  logic [19:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [19:0] data_address_o,
  output logic [19:0] granted_bytes_o
);

  ffba_pkg::ctl_t ctl;   // controller commands
  ffba_pkg::sts_t sts;   // datapath status

  ffba_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  ffba_datapath u_dp (
    .clk_i, .rst_ni, .kind_i, .size_bytes_i, .address_i,
    .ctl_i(ctl), .sts_o(sts), .status_o, .data_address_o, .granted_bytes_o
  );

endmodule
